>>> rtl/strict_json_syntax_validator_unit_assert.svh
// Assertion macros shared by the JSON validator RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef STRICT_JSON_SYNTAX_VALIDATOR_UNIT_ASSERT_SVH
`define STRICT_JSON_SYNTAX_VALIDATOR_UNIT_ASSERT_SVH

// Condition implies consequence in the same cycle
`define JSVU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle
`define JSVU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/jsv_pkg.sv
// Shared types, character codes and literal tables for the JSON validator.
// No dependencies; used by all RTL modules of the block.
package jsv_pkg;

    // Default nesting limit
    localparam int MAX_DEPTH_DEF = 32;

    // Lexer phases
    typedef enum logic [4:0] {
        PH_VALUE     = 5'd0,
        PH_ARR_FIRST = 5'd1,
        PH_OBJ_FIRST = 5'd2,
        PH_KEY       = 5'd3,
        PH_KEY_STR   = 5'd4,
        PH_KEY_ESC   = 5'd5,
        PH_COLON     = 5'd6,
        PH_STR       = 5'd7,
        PH_STR_ESC   = 5'd8,
        PH_AFTER     = 5'd9,
        PH_LIT_T     = 5'd10,
        PH_LIT_F     = 5'd11,
        PH_LIT_N     = 5'd12,
        PH_NUM_MINUS = 5'd13,
        PH_NUM_ZERO  = 5'd14,
        PH_NUM_INT   = 5'd15,
        PH_NUM_DOT   = 5'd16,
        PH_NUM_FRAC  = 5'd17,
        PH_NUM_E     = 5'd18,
        PH_NUM_ESIGN = 5'd19,
        PH_NUM_EXP   = 5'd20
    } phase_t;

    // Container kind held on the stack
    typedef enum logic {
        KIND_OBJECT = 1'b0,
        KIND_ARRAY  = 1'b1
    } kind_t;

    // Literal selector
    typedef enum logic [1:0] {
        LIT_TRUE  = 2'd0,
        LIT_FALSE = 2'd1,
        LIT_NULL  = 2'd2
    } lit_sel_t;

    // Stack control from lexer to stack
    typedef struct packed {
        logic  push;
        logic  pop;
        kind_t kind;
    } stk_ctrl_t;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CTRL   = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Length of each literal
    function automatic logic [2:0] lit_len(input lit_sel_t sel);
        case (sel)
            LIT_FALSE: lit_len = 3'd5;
            default:   lit_len = 3'd4;
        endcase
    endfunction

    // Expected character of a literal at a given position
    function automatic logic [7:0] lit_char(input lit_sel_t sel, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (sel)
            LIT_TRUE:
            begin
                case (pos)
                    3'd0:    ch = CH_T;
                    3'd1:    ch = CH_R;
                    3'd2:    ch = CH_U;
                    3'd3:    ch = CH_E;
                    default: ch = 8'h00;
                endcase
            end
            LIT_FALSE:
            begin
                case (pos)
                    3'd0:    ch = CH_F;
                    3'd1:    ch = CH_A;
                    3'd2:    ch = CH_L;
                    3'd3:    ch = CH_S;
                    3'd4:    ch = CH_E;
                    default: ch = 8'h00;
                endcase
            end
            LIT_NULL:
            begin
                case (pos)
                    3'd0:    ch = CH_N;
                    3'd1:    ch = CH_U;
                    3'd2:    ch = CH_L;
                    3'd3:    ch = CH_L;
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> rtl/jsv_stack.sv
// Container-kind stack of the JSON validator, built as a shift line.
// Depends on jsv_pkg for the kind and control types.
module jsv_stack #(
    parameter int DEPTH = jsv_pkg::MAX_DEPTH_DEF + 1
) (
    input  logic              clk,
    input  jsv_pkg::stk_ctrl_t ctrl,
    output jsv_pkg::kind_t    top
);

    logic [DEPTH-1:0] stack_reg;
    logic [DEPTH-1:0] stack_next;

    // Shift in on push, shift out on pop; top of stack sits at bit 0
    always_comb
    begin
        stack_next = stack_reg;
        if (ctrl.push)
        begin
            stack_next = {stack_reg[DEPTH-2:0], ctrl.kind};
        end
        else if (ctrl.pop)
        begin
            stack_next = {stack_reg[DEPTH-1], stack_reg[DEPTH-1:1]};
        end
    end

    // Entries are payload and hold no reset value
    always_ff @(posedge clk)
    begin
        stack_reg <= stack_next;
    end

    assign top = jsv_pkg::kind_t'(stack_reg[0]);

endmodule

>>> rtl/jsv_lexer.sv
// Byte-level lexer and grammar checker of the JSON validator.
// Depends on jsv_pkg and the assertion macro header; drives the stack.
`include "strict_json_syntax_validator_unit_assert.svh"

module jsv_lexer #(
    parameter int MAX_DEPTH = jsv_pkg::MAX_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  logic [7:0]         text_byte,
    input  logic               end_of_text,
    input  jsv_pkg::kind_t     stk_top,
    output jsv_pkg::stk_ctrl_t stk,
    output logic               text_valid
);

    localparam int LEVEL_W = $clog2(MAX_DEPTH + 2);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = LEVEL_W'(MAX_DEPTH);
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(MAX_DEPTH + 1);

    jsv_pkg::phase_t     phase_reg, phase_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [2:0]          lit_pos_reg, lit_pos_next;
    logic                err_reg, err_next;

    jsv_pkg::phase_t     phase_cur;
    jsv_pkg::phase_t     fin_phase;
    jsv_pkg::kind_t      close_kind;
    jsv_pkg::lit_sel_t   lit_sel;
    jsv_pkg::stk_ctrl_t  stk_raw;
    logic                consumed;
    logic                do_begin;
    logic                do_close;
    logic                is_space;
    logic                is_digit;
    logic                exp_mark;
    logic                esc_ok;

    // Classify the byte
    always_comb
    begin
        is_space = text_byte inside {jsv_pkg::CH_SPACE, jsv_pkg::CH_TAB,
                                     jsv_pkg::CH_LF, jsv_pkg::CH_CR};
        is_digit = text_byte inside {[jsv_pkg::CH_0:jsv_pkg::CH_9]};
        exp_mark = text_byte inside {jsv_pkg::CH_E, jsv_pkg::CH_UPPER_E};
        esc_ok   = text_byte inside {jsv_pkg::CH_QUOTE, jsv_pkg::CH_BSLASH,
                                     jsv_pkg::CH_SLASH, jsv_pkg::CH_B, jsv_pkg::CH_F,
                                     jsv_pkg::CH_N, jsv_pkg::CH_R, jsv_pkg::CH_T};
    end

    // Next state for one byte
    always_comb
    begin
        phase_next   = phase_reg;
        level_next   = level_reg;
        lit_pos_next = lit_pos_reg;
        err_next     = err_reg;
        stk_raw      = '0;
        phase_cur    = phase_reg;
        consumed     = 1'b0;
        do_begin     = 1'b0;
        do_close     = 1'b0;
        close_kind   = jsv_pkg::KIND_OBJECT;
        lit_sel      = jsv_pkg::LIT_TRUE;

        if (!err_reg)
        begin
            // Number phases: consume the byte or end the number
            case (phase_reg)
                jsv_pkg::PH_NUM_MINUS:
                begin
                    consumed = 1'b1;
                    if (text_byte == jsv_pkg::CH_0)
                        phase_next = jsv_pkg::PH_NUM_ZERO;
                    else if (text_byte inside {[jsv_pkg::CH_1:jsv_pkg::CH_9]})
                        phase_next = jsv_pkg::PH_NUM_INT;
                    else
                        err_next = 1'b1;
                end
                jsv_pkg::PH_NUM_ZERO, jsv_pkg::PH_NUM_INT:
                begin
                    if (phase_reg == jsv_pkg::PH_NUM_INT && is_digit)
                        consumed = 1'b1;
                    else if (text_byte == jsv_pkg::CH_DOT)
                    begin
                        consumed   = 1'b1;
                        phase_next = jsv_pkg::PH_NUM_DOT;
                    end
                    else if (exp_mark)
                    begin
                        consumed   = 1'b1;
                        phase_next = jsv_pkg::PH_NUM_E;
                    end
                end
                jsv_pkg::PH_NUM_DOT:
                begin
                    consumed = 1'b1;
                    if (is_digit)
                        phase_next = jsv_pkg::PH_NUM_FRAC;
                    else
                        err_next = 1'b1;
                end
                jsv_pkg::PH_NUM_FRAC:
                begin
                    if (is_digit)
                        consumed = 1'b1;
                    else if (exp_mark)
                    begin
                        consumed   = 1'b1;
                        phase_next = jsv_pkg::PH_NUM_E;
                    end
                end
                jsv_pkg::PH_NUM_E:
                begin
                    consumed = 1'b1;
                    if (text_byte == jsv_pkg::CH_PLUS || text_byte == jsv_pkg::CH_MINUS)
                        phase_next = jsv_pkg::PH_NUM_ESIGN;
                    else if (is_digit)
                        phase_next = jsv_pkg::PH_NUM_EXP;
                    else
                        err_next = 1'b1;
                end
                jsv_pkg::PH_NUM_ESIGN:
                begin
                    consumed = 1'b1;
                    if (is_digit)
                        phase_next = jsv_pkg::PH_NUM_EXP;
                    else
                        err_next = 1'b1;
                end
                jsv_pkg::PH_NUM_EXP:
                begin
                    if (is_digit)
                        consumed = 1'b1;
                end
                default:
                begin
                    consumed = 1'b0;
                end
            endcase

            // A finished number hands the byte on as the one after a value
            if (!consumed && phase_reg inside {[jsv_pkg::PH_NUM_MINUS:jsv_pkg::PH_NUM_EXP]})
            begin
                phase_cur  = jsv_pkg::PH_AFTER;
                phase_next = jsv_pkg::PH_AFTER;
            end

            if (!consumed)
            begin
                case (phase_cur)
                    jsv_pkg::PH_VALUE:
                    begin
                        if (!is_space)
                            do_begin = 1'b1;
                    end
                    jsv_pkg::PH_ARR_FIRST:
                    begin
                        if (text_byte == jsv_pkg::CH_RBRACK)
                        begin
                            do_close   = 1'b1;
                            close_kind = jsv_pkg::KIND_ARRAY;
                        end
                        else if (!is_space)
                            do_begin = 1'b1;
                    end
                    jsv_pkg::PH_OBJ_FIRST, jsv_pkg::PH_KEY:
                    begin
                        if (is_space)
                            phase_next = phase_cur;
                        else if (text_byte == jsv_pkg::CH_QUOTE)
                            phase_next = jsv_pkg::PH_KEY_STR;
                        else if (text_byte == jsv_pkg::CH_RBRACE &&
                                 phase_cur == jsv_pkg::PH_OBJ_FIRST)
                        begin
                            do_close   = 1'b1;
                            close_kind = jsv_pkg::KIND_OBJECT;
                        end
                        else
                            err_next = 1'b1;
                    end
                    jsv_pkg::PH_KEY_STR, jsv_pkg::PH_STR:
                    begin
                        if (text_byte < jsv_pkg::CH_CTRL)
                            err_next = 1'b1;
                        else if (text_byte == jsv_pkg::CH_QUOTE)
                            phase_next = (phase_cur == jsv_pkg::PH_KEY_STR)
                                ? jsv_pkg::PH_COLON : jsv_pkg::PH_AFTER;
                        else if (text_byte == jsv_pkg::CH_BSLASH)
                            phase_next = (phase_cur == jsv_pkg::PH_KEY_STR)
                                ? jsv_pkg::PH_KEY_ESC : jsv_pkg::PH_STR_ESC;
                    end
                    jsv_pkg::PH_KEY_ESC, jsv_pkg::PH_STR_ESC:
                    begin
                        if (esc_ok)
                            phase_next = (phase_cur == jsv_pkg::PH_KEY_ESC)
                                ? jsv_pkg::PH_KEY_STR : jsv_pkg::PH_STR;
                        else
                            err_next = 1'b1;
                    end
                    jsv_pkg::PH_COLON:
                    begin
                        if (text_byte == jsv_pkg::CH_COLON)
                            phase_next = jsv_pkg::PH_VALUE;
                        else if (!is_space)
                            err_next = 1'b1;
                    end
                    jsv_pkg::PH_LIT_T, jsv_pkg::PH_LIT_F, jsv_pkg::PH_LIT_N:
                    begin
                        if (phase_cur == jsv_pkg::PH_LIT_T)
                            lit_sel = jsv_pkg::LIT_TRUE;
                        else if (phase_cur == jsv_pkg::PH_LIT_F)
                            lit_sel = jsv_pkg::LIT_FALSE;
                        else
                            lit_sel = jsv_pkg::LIT_NULL;
                        if (lit_pos_reg >= jsv_pkg::lit_len(lit_sel) ||
                            text_byte != jsv_pkg::lit_char(lit_sel, lit_pos_reg))
                            err_next = 1'b1;
                        else if (lit_pos_reg + 3'd1 == jsv_pkg::lit_len(lit_sel))
                        begin
                            lit_pos_next = 3'd0;
                            phase_next   = jsv_pkg::PH_AFTER;
                        end
                        else
                            lit_pos_next = lit_pos_reg + 3'd1;
                    end
                    jsv_pkg::PH_AFTER:
                    begin
                        if (is_space)
                            phase_next = phase_cur;
                        else if (level_reg == '0)
                            err_next = 1'b1;
                        else if (text_byte == jsv_pkg::CH_COMMA)
                            phase_next = (stk_top == jsv_pkg::KIND_OBJECT)
                                ? jsv_pkg::PH_KEY : jsv_pkg::PH_VALUE;
                        else if (text_byte == jsv_pkg::CH_RBRACE)
                        begin
                            do_close   = 1'b1;
                            close_kind = jsv_pkg::KIND_OBJECT;
                        end
                        else if (text_byte == jsv_pkg::CH_RBRACK)
                        begin
                            do_close   = 1'b1;
                            close_kind = jsv_pkg::KIND_ARRAY;
                        end
                        else
                            err_next = 1'b1;
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end

            // Start a value: string, container, literal or number
            if (do_begin)
            begin
                if (level_reg > LEVEL_MAX)
                    err_next = 1'b1;
                else
                begin
                    lit_pos_next = 3'd0;
                    case (text_byte)
                        jsv_pkg::CH_QUOTE:  phase_next = jsv_pkg::PH_STR;
                        jsv_pkg::CH_LBRACE:
                        begin
                            stk_raw.push = 1'b1;
                            stk_raw.kind = jsv_pkg::KIND_OBJECT;
                            level_next   = level_reg + 1'b1;
                            phase_next   = jsv_pkg::PH_OBJ_FIRST;
                        end
                        jsv_pkg::CH_LBRACK:
                        begin
                            stk_raw.push = 1'b1;
                            stk_raw.kind = jsv_pkg::KIND_ARRAY;
                            level_next   = level_reg + 1'b1;
                            phase_next   = jsv_pkg::PH_ARR_FIRST;
                        end
                        jsv_pkg::CH_T:
                        begin
                            phase_next   = jsv_pkg::PH_LIT_T;
                            lit_pos_next = 3'd1;
                        end
                        jsv_pkg::CH_F:
                        begin
                            phase_next   = jsv_pkg::PH_LIT_F;
                            lit_pos_next = 3'd1;
                        end
                        jsv_pkg::CH_N:
                        begin
                            phase_next   = jsv_pkg::PH_LIT_N;
                            lit_pos_next = 3'd1;
                        end
                        jsv_pkg::CH_MINUS:  phase_next = jsv_pkg::PH_NUM_MINUS;
                        jsv_pkg::CH_0:      phase_next = jsv_pkg::PH_NUM_ZERO;
                        default:
                        begin
                            if (text_byte inside {[jsv_pkg::CH_1:jsv_pkg::CH_9]})
                                phase_next = jsv_pkg::PH_NUM_INT;
                            else
                                err_next = 1'b1;
                        end
                    endcase
                end
            end

            // Close a container if the kind on top matches
            if (do_close)
            begin
                if (level_reg == '0 || stk_top != close_kind)
                    err_next = 1'b1;
                else
                begin
                    stk_raw.pop = 1'b1;
                    level_next  = level_reg - 1'b1;
                    phase_next  = jsv_pkg::PH_AFTER;
                end
            end
        end

        // End of text: a complete number counts as a finished value
        fin_phase = phase_next;
        if (phase_next inside {jsv_pkg::PH_NUM_ZERO, jsv_pkg::PH_NUM_INT,
                               jsv_pkg::PH_NUM_FRAC, jsv_pkg::PH_NUM_EXP})
            fin_phase = jsv_pkg::PH_AFTER;
        text_valid = !err_next && level_next == '0 && fin_phase == jsv_pkg::PH_AFTER;

        // Return to the start state after the last byte
        if (end_of_text)
        begin
            phase_next   = jsv_pkg::PH_VALUE;
            level_next   = '0;
            lit_pos_next = 3'd0;
            err_next     = 1'b0;
        end
    end

    // Gate stack moves with the step
    assign stk = step_en ? stk_raw : '0;

    // Lexer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= jsv_pkg::PH_VALUE;
            level_reg   <= '0;
            lit_pos_reg <= 3'd0;
            err_reg     <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            level_reg   <= level_next;
            lit_pos_reg <= lit_pos_next;
            err_reg     <= err_next;
        end
    end

    `JSVU_ASSERT_NOW(a_level_bound, 1'b1, level_reg <= LEVEL_FULL,
        "nesting level beyond stack depth")
    `JSVU_ASSERT_NEXT(a_err_sticky, err_reg && !(step_en && end_of_text), err_reg,
        "error flag cleared before end of text")
    `JSVU_ASSERT_NEXT(a_restart, step_en && end_of_text,
        phase_reg == jsv_pkg::PH_VALUE && level_reg == '0 && !err_reg,
        "lexer not back at start after last byte")

endmodule

>>> rtl/strict_json_syntax_validator_unit.sv
// The verdict for a text is registered in the result register when its last byte steps the lexer.
// Throughput: one byte per cycle unless a last byte stalls; lexer state and stack shift update together.
// A last byte waits in the input register only while an earlier result is unread.
// Reset (rst_n low, asynchronous) empties both registers and returns the lexer to
// its start state; the stack contents are not cleared and need not be.
module strict_json_syntax_validator_unit #(
    parameter int MAX_DEPTH = jsv_pkg::MAX_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tlast,   // end_of_text
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] text_valid, [7:1] zero
);

    `include "strict_json_syntax_validator_unit_assert.svh"

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_bit_reg, out_bit_next;
    logic               advance;
    logic               text_valid;
    jsv_pkg::stk_ctrl_t stk;
    jsv_pkg::kind_t     stk_top;

    // Only a last byte can stall, and only on a full result register
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register control
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
            in_valid_next = s_axis_tvalid;
    end

    // Result register control
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_bit_next   = out_bit_reg;
        if (advance && in_last_reg)
        begin
            out_valid_next = 1'b1;
            out_bit_next   = text_valid;
        end
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload on each transfer
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        out_bit_reg <= out_bit_next;
    end

    jsv_lexer #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .text_byte   (in_byte_reg),
        .end_of_text (in_last_reg),
        .stk_top     (stk_top),
        .stk         (stk),
        .text_valid  (text_valid)
    );

    jsv_stack #(
        .DEPTH (MAX_DEPTH + 1)
    ) u_stack (
        .clk  (clk),
        .ctrl (stk),
        .top  (stk_top)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_bit_reg};

    `JSVU_ASSERT_NOW(a_no_stall_mid_text, in_valid_reg && !in_last_reg, advance,
        "byte inside a text stalled")
    `JSVU_ASSERT_NEXT(a_result_loaded, advance && in_last_reg, out_valid_reg,
        "last byte gave no result")
    `JSVU_ASSERT_NEXT(a_result_held, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

endmodule
